// ===== rtl/core/u8dec_pkg.sv =====
// Shared types and constants for the UTF-8 stream decoder.
package u8dec_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned REM_W  = 2;

  // Lead byte classes: mask and expected pattern
  localparam logic [BYTE_W-1:0] ASCII_LIMIT = 8'h80;
  localparam logic [BYTE_W-1:0] LEAD2_MASK  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_CODE  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_CODE  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MASK  = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_CODE  = 8'hF0;

  // Payload masks
  localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;
  localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;

  localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

  // Further bytes expected after a lead byte
  localparam logic [REM_W-1:0] REM_NONE  = 2'd0;
  localparam logic [REM_W-1:0] REM_ONE   = 2'd1;
  localparam logic [REM_W-1:0] REM_TWO   = 2'd2;
  localparam logic [REM_W-1:0] REM_THREE = 2'd3;

  // One raw byte with its end-of-string mark
  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_string;
  } byte_item_t;

  // One decoded result
  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            last_in_string;
  } cp_item_t;

endpackage

// ===== rtl/core/u8dec_in_stage.sv =====
// Input register stage: captures one byte transfer per cycle while its output is not stalled.
module u8dec_in_stage (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 s_valid,
  output logic                 s_ready,
  input  u8dec_pkg::byte_item_t s_item,
  output logic                 m_valid,
  input  logic                 m_ready,
  output u8dec_pkg::byte_item_t m_item
);

  logic                  vld_r;
  logic                  vld_nxt;
  u8dec_pkg::byte_item_t item_r;

  // Accept whenever the held byte is empty or leaving this cycle
  assign s_ready = !vld_r || m_ready;
  assign vld_nxt = s_ready ? s_valid : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Load payload on each input transfer
  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      item_r <= s_item;
    end
  end

  assign m_valid = vld_r;
  assign m_item  = item_r;

endmodule

// ===== rtl/core/u8dec_core.sv =====
// Decode step: sequence state and combinational byte decode.
module u8dec_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  u8dec_pkg::byte_item_t item,
  output logic                  emit,
  output u8dec_pkg::cp_item_t   result
);

  logic [u8dec_pkg::REM_W-1:0]  rem_r;
  logic [u8dec_pkg::REM_W-1:0]  rem_nxt;
  logic [u8dec_pkg::CP_W-1:0]   acc_r;
  logic [u8dec_pkg::CP_W-1:0]   acc_nxt;
  logic [u8dec_pkg::CP_W-1:0]   acc_new;
  logic [u8dec_pkg::REM_W-1:0]  rem_new;
  logic [u8dec_pkg::BYTE_W-1:0] b;
  logic                         eos;

  assign b   = item.in_byte;
  assign eos = item.end_of_string;

  // Classify the byte and build the next accumulator
  always_comb begin
    emit                  = 1'b0;
    result.code_point     = acc_r;
    result.last_in_string = eos;
    acc_new               = acc_r;
    rem_new               = rem_r;
    if (rem_r == u8dec_pkg::REM_NONE) begin
      if (b < u8dec_pkg::ASCII_LIMIT) begin
        emit              = 1'b1;
        result.code_point = {{(u8dec_pkg::CP_W-u8dec_pkg::BYTE_W){1'b0}}, b};
      end else if ((b & u8dec_pkg::LEAD2_MASK) == u8dec_pkg::LEAD2_CODE) begin
        rem_new = u8dec_pkg::REM_ONE;
        acc_new = {{(u8dec_pkg::CP_W-u8dec_pkg::BYTE_W){1'b0}}, b & u8dec_pkg::LEAD2_BITS};
      end else if ((b & u8dec_pkg::LEAD3_MASK) == u8dec_pkg::LEAD3_CODE) begin
        rem_new = u8dec_pkg::REM_TWO;
        acc_new = {{(u8dec_pkg::CP_W-u8dec_pkg::BYTE_W){1'b0}}, b & u8dec_pkg::LEAD3_BITS};
      end else if ((b & u8dec_pkg::LEAD4_MASK) == u8dec_pkg::LEAD4_CODE) begin
        rem_new = u8dec_pkg::REM_THREE;
        acc_new = {{(u8dec_pkg::CP_W-u8dec_pkg::BYTE_W){1'b0}}, b & u8dec_pkg::LEAD4_BITS};
      end else begin
        emit              = 1'b1;
        result.code_point = u8dec_pkg::REPLACEMENT_CP;
      end
      // Lead byte that ends the string: flush its payload bits
      if (!emit && eos) begin
        emit              = 1'b1;
        result.code_point = acc_new;
      end
    end else begin
      acc_new = {acc_r[u8dec_pkg::CP_W-7:0], b[5:0] & u8dec_pkg::CONT_BITS[5:0]};
      rem_new = rem_r - u8dec_pkg::REM_ONE;
      if ((rem_new == u8dec_pkg::REM_NONE) || eos) begin
        emit              = 1'b1;
        result.code_point = acc_new;
      end
    end
  end

  // Return to idle after every result
  always_comb begin
    rem_nxt = rem_r;
    acc_nxt = acc_r;
    if (step) begin
      if (emit) begin
        rem_nxt = u8dec_pkg::REM_NONE;
        acc_nxt = '0;
      end else begin
        rem_nxt = rem_new;
        acc_nxt = acc_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= u8dec_pkg::REM_NONE;
      acc_r <= '0;
    end else begin
      rem_r <= rem_nxt;
      acc_r <= acc_nxt;
    end
  end

endmodule

// ===== rtl/core/u8dec_out_stage.sv =====
// Result register stage: holds one code point until the sink takes it.
module u8dec_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                ready,
  input  u8dec_pkg::cp_item_t s_item,
  output logic                m_valid,
  input  logic                m_ready,
  output u8dec_pkg::cp_item_t m_item
);

  logic                vld_r;
  logic                vld_nxt;
  u8dec_pkg::cp_item_t item_r;

  // Free when empty or draining this cycle
  assign ready   = !vld_r || m_ready;
  assign vld_nxt = ready ? push : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && ready) begin
      item_r <= s_item;
    end
  end

  assign m_valid = vld_r;
  assign m_item  = item_r;

endmodule

// ===== rtl/core/utf8_stream_decoder.sv =====
// UTF-8 stream decoder top level: input register, decode step, result register.
//
//   channel | direction | tdata                    | tlast
//   in_     | slave     | [7:0] in_byte            | end_of_string
//   out_    | master    | [20:0] code_point, pad 0 | last_in_string
//
// One byte per clock sustained while out_tready stays high; a transferred byte is
// held in the input register, then decoded into the result register when it is free.
// The decode step advances only when the result register is free or draining,
// so a stall on out_tready backs up through both registers to in_tready.
// Reset (rst_n low, synchronous) empties both registers and drops any open
// sequence.
module utf8_stream_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // end_of_string
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] zero
  output logic        out_tlast   // last_in_string
);

  u8dec_pkg::byte_item_t in_item;
  u8dec_pkg::byte_item_t held_item;
  u8dec_pkg::cp_item_t   dec_item;
  u8dec_pkg::cp_item_t   out_item;
  logic                  held_vld;
  logic                  out_rdy;
  logic                  step;
  logic                  emit;

  assign in_item.in_byte       = in_tdata;
  assign in_item.end_of_string = in_tlast;

  u8dec_in_stage u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_tvalid),
    .s_ready (in_tready),
    .s_item  (in_item),
    .m_valid (held_vld),
    .m_ready (out_rdy),
    .m_item  (held_item)
  );

  // Advance one byte when the result register can take its output
  assign step = held_vld && out_rdy;

  u8dec_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (held_item),
    .emit   (emit),
    .result (dec_item)
  );

  u8dec_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (step && emit),
    .ready   (out_rdy),
    .s_item  (dec_item),
    .m_valid (out_tvalid),
    .m_ready (out_tready),
    .m_item  (out_item)
  );

  assign out_tdata = {3'b000, out_item.code_point};
  assign out_tlast = out_item.last_in_string;

endmodule

// ===== sim/utf8_stream_decoder_tb.sv =====
// Self-checking testbench for the UTF-8 stream decoder: directed table plus random strings.
module utf8_stream_decoder_tb;
  import u8dec_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int DIRECTED_ROWS = 23;

  // One directed byte; pinned rows carry a hand-written code point
  typedef struct packed {
    logic [7:0]      in_byte;
    logic            end_of_string;
    logic            pinned;
    logic [CP_W-1:0] code_point;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] in_byte
  logic        in_tlast = 1'b0;    // end_of_string
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;          // [20:0] code_point, [23:21] zero
  logic        out_tlast;          // last_in_string

  // Decoder state mirrored by the testbench
  logic [REM_W-1:0] seq_left = REM_NONE;
  logic [CP_W-1:0]  cp_acc = '0;

  cp_item_t pending_cps [$];
  int       bytes_sent = 0;
  int       fail_count = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  logic     hold_toggle = 1'b0;
  logic     hold_seen = 1'b0;
  int       hold_left = 0;

  // Extremes, invalid leads, each sequence length, truncation at the lead and after one continuation
  dir_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, 21'h000000},
    '{8'h7F, 1'b1, 1'b1, 21'h00007F},
    '{8'h80, 1'b0, 1'b1, REPLACEMENT_CP},
    '{8'hFF, 1'b1, 1'b1, REPLACEMENT_CP},
    '{8'hF8, 1'b0, 1'b1, REPLACEMENT_CP},
    '{8'hC3, 1'b0, 1'b0, 21'h0},
    '{8'hA9, 1'b0, 1'b0, 21'h0},
    '{8'hE2, 1'b0, 1'b0, 21'h0},
    '{8'h82, 1'b0, 1'b0, 21'h0},
    '{8'hAC, 1'b1, 1'b0, 21'h0},
    '{8'hF0, 1'b0, 1'b0, 21'h0},
    '{8'h9F, 1'b0, 1'b0, 21'h0},
    '{8'h98, 1'b0, 1'b0, 21'h0},
    '{8'h80, 1'b0, 1'b0, 21'h0},
    '{8'hF7, 1'b0, 1'b0, 21'h0},
    '{8'hBF, 1'b0, 1'b0, 21'h0},
    '{8'hBF, 1'b0, 1'b0, 21'h0},
    '{8'hBF, 1'b1, 1'b1, 21'h1FFFFF},
    '{8'hE2, 1'b0, 1'b0, 21'h0},
    '{8'h41, 1'b1, 1'b0, 21'h0},
    '{8'hDF, 1'b1, 1'b1, 21'h00001F},
    '{8'hF4, 1'b0, 1'b0, 21'h0},
    '{8'h8F, 1'b1, 1'b0, 21'h0}
  };

  utf8_stream_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // Advance the mirrored decoder by one byte; return 1 when a code point comes out
  function automatic bit decode_byte(input logic [7:0] b, input logic eos,
                                     output cp_item_t res);
    res = '0;
    if (seq_left == REM_NONE) begin
      if (b < ASCII_LIMIT) begin
        res.code_point     = CP_W'(b);
        res.last_in_string = eos;
        return 1'b1;
      end
      if ((b & LEAD2_MASK) == LEAD2_CODE) begin
        seq_left = REM_ONE;
        cp_acc   = CP_W'(b & LEAD2_BITS);
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
        seq_left = REM_TWO;
        cp_acc   = CP_W'(b & LEAD3_BITS);
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
        seq_left = REM_THREE;
        cp_acc   = CP_W'(b & LEAD4_BITS);
      end else begin
        res.code_point     = REPLACEMENT_CP;
        res.last_in_string = eos;
        return 1'b1;
      end
      // Lead byte that ends the string: emit its payload bits
      if (eos) begin
        res.code_point     = cp_acc;
        res.last_in_string = 1'b1;
        seq_left = REM_NONE;
        cp_acc   = '0;
        return 1'b1;
      end
      return 1'b0;
    end
    // Inside a sequence: shift in six bits, no continuation check
    cp_acc   = {cp_acc[CP_W-7:0], b[5:0]};
    seq_left = seq_left - 1'b1;
    if (seq_left == REM_NONE || eos) begin
      res.code_point     = cp_acc;
      res.last_in_string = eos;
      seq_left = REM_NONE;
      cp_acc   = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Offer one byte, wait for its transfer, then record what it should produce
  task automatic send_byte(input logic [7:0] b, input logic eos, input logic pinned,
                           input logic [CP_W-1:0] pinned_cp);
    cp_item_t res;
    bit       has_res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    has_res = decode_byte(b, eos, res);
    if (pinned) begin
      res.code_point     = pinned_cp;
      res.last_in_string = eos;
      has_res = 1'b1;
    end
    if (has_res)
      pending_cps.push_back(res);
  endtask

  // Build one string: mostly well-formed characters, some noise and truncation
  task automatic send_random_string();
    logic [7:0] seq [$];
    int         n_chars;
    int         kind;
    int         n_cont;
    int         cut;
    logic [7:0] lead;
    n_chars = $urandom_range(1, 6);
    repeat (n_chars) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        seq.push_back(8'($urandom_range(0, 127)));
      end else if (kind < 85) begin
        n_cont = (kind < 50) ? 1 : (kind < 70) ? 2 : 3;
        case (n_cont)
          1: lead = LEAD2_CODE | 8'($urandom_range(0, 31));
          2: lead = LEAD3_CODE | 8'($urandom_range(0, 15));
          default: lead = LEAD4_CODE | 8'($urandom_range(0, 7));
        endcase
        seq.push_back(lead);
        repeat (n_cont) begin
          if ($urandom_range(0, 19) == 0)
            seq.push_back(8'($urandom));
          else
            seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end
      end else begin
        seq.push_back(8'($urandom));
      end
    end
    // Cut the string short now and then, often inside a sequence
    if ($urandom_range(0, 6) == 0) begin
      cut = $urandom_range(1, seq.size());
      while (seq.size() > cut)
        void'(seq.pop_back());
    end
    foreach (seq[i])
      send_byte(seq[i], i == seq.size() - 1, 1'b0, '0);
  endtask

  task automatic run_strings(input int n_bytes, input int idle_pct, input int stall_pct);
    int target;
    target = bytes_sent + n_bytes;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (bytes_sent < target)
      send_random_string();
  endtask

  // Drive out_tready: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Compare each result transfer with the oldest pending code point
  always @(posedge clk) begin
    cp_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_cps.size() == 0) begin
        $error("unexpected result: code_point %h last_in_string %b",
               out_tdata[CP_W-1:0], out_tlast);
        fail_count++;
      end else begin
        want = pending_cps.pop_front();
        if (out_tdata[CP_W-1:0] !== want.code_point) begin
          $error("code_point: expected %h, got %h", want.code_point, out_tdata[CP_W-1:0]);
          fail_count++;
        end
        if (out_tlast !== want.last_in_string) begin
          $error("last_in_string: expected %b, got %b", want.last_in_string, out_tlast);
          fail_count++;
        end
        if (out_tdata[23:CP_W] !== 3'b000) begin
          $error("tdata padding: expected 000, got %b", out_tdata[23:CP_W]);
          fail_count++;
        end
      end
    end
  end

  // Stimulus sequence
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_rows[i])
      send_byte(directed_rows[i].in_byte, directed_rows[i].end_of_string,
                directed_rows[i].pinned, directed_rows[i].code_point);
    run_strings(400, 0, 0);
    run_strings(400, 84, 0);
    run_strings(400, 0, 84);
    run_strings(400, 36, 36);
    // Long receiver hold-off while bytes keep coming
    hold_toggle <= ~hold_toggle;
    run_strings(150, 0, 0);
    in_tvalid <= 1'b0;
    while (pending_cps.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
